// File: rtl/ntcdtl_pkg.sv
package ntcdtl_pkg;

  localparam int STORED_ENTRIES    = 42;
  localparam int TABLE_ENTRIES_DEF = 42;
  localparam int STORED_IDX_W      = 6;

  localparam int ADC_W    = 16;
  localparam int SUP_W    = 13;
  localparam int DIVR_W   = 20;
  localparam int OHM_W    = 24;
  localparam int RES_W    = 32;
  localparam int TEMP_W   = 15;
  localparam int STATUS_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NTC_UPPER = 2'd2;

  localparam logic [SUP_W-1:0]  SUPPLY_RST  = 13'd3000;
  localparam logic [DIVR_W-1:0] DIVIDER_RST = 20'd10000;

  localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW = 2'd2;

  localparam int LOWEST_CENTI = -5500;
  localparam int STEP_CENTI   = 500;

  // shared restoring divider
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_CNT_W = 6;
  localparam int DIV_FULL  = 40;
  localparam int DIV_SHORT = 10;

  typedef enum logic [2:0] {
    SEL_COLD_FLAG,
    SEL_HOT_FLAG,
    SEL_COLD,
    SEL_HOT,
    SEL_INTERP
  } res_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     mul;
    logic     span_sel;
    logic     div1_start;
    logic     res_load;
    logic     srch_step;
    logic     div2_start;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic gt;
    logic lt;
    logic div_busy;
    logic clamp_cold;
    logic clamp_hot;
    logic srch_done;
  } sts_t;

  function automatic int used_entries(input int n);
    int u;
    u = (n < STORED_ENTRIES) ? n : STORED_ENTRIES;
    if (u < 2) begin
      u = 2;
    end
    return u;
  endfunction

  // ntc resistance per 5 degree step, ohms with 4 fraction bits
  function automatic logic [OHM_W-1:0] ohms_q4(input logic [STORED_IDX_W-1:0] idx);
    logic [OHM_W-1:0] r;
    unique case (idx)
      6'd0:    r = 24'd15385280;
      6'd1:    r = 24'd10702720;
      6'd2:    r = 24'd7540320;
      6'd3:    r = 24'd5376960;
      6'd4:    r = 24'd3878880;
      6'd5:    r = 24'd2828960;
      6'd6:    r = 24'd2085120;
      6'd7:    r = 24'd1552320;
      6'd8:    r = 24'd1166768;
      6'd9:    r = 24'd885024;
      6'd10:   r = 24'd677200;
      6'd11:   r = 24'd522512;
      6'd12:   r = 24'd406400;
      6'd13:   r = 24'd318512;
      6'd14:   r = 24'd251456;
      6'd15:   r = 24'd199904;
      6'd16:   r = 24'd160000;
      6'd17:   r = 24'd128883;
      6'd18:   r = 24'd104461;
      6'd19:   r = 24'd85166;
      6'd20:   r = 24'd69832;
      6'd21:   r = 24'd57570;
      6'd22:   r = 24'd47710;
      6'd23:   r = 24'd39739;
      6'd24:   r = 24'd33259;
      6'd25:   r = 24'd27966;
      6'd26:   r = 24'd23621;
      6'd27:   r = 24'd20037;
      6'd28:   r = 24'd17067;
      6'd29:   r = 24'd14596;
      6'd30:   r = 24'd12531;
      6'd31:   r = 24'd10798;
      6'd32:   r = 24'd9338;
      6'd33:   r = 24'd8104;
      6'd34:   r = 24'd7056;
      6'd35:   r = 24'd6163;
      6'd36:   r = 24'd5400;
      6'd37:   r = 24'd4746;
      6'd38:   r = 24'd4183;
      6'd39:   r = 24'd3698;
      6'd40:   r = 24'd3277;
      6'd41:   r = 24'd2912;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ntcdtl_in_if.sv
interface ntcdtl_in_if;
  logic                           valid;
  logic                           ready;
  logic [ntcdtl_pkg::ADC_W-1:0]   adc_millivolts;

  modport source (output valid, output adc_millivolts, input ready);
  modport sink   (input valid, input adc_millivolts, output ready);
endinterface

// File: rtl/ntcdtl_out_if.sv
interface ntcdtl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ntcdtl_pkg::TEMP_W-1:0] temperature_centi;
  logic [ntcdtl_pkg::STATUS_W-1:0]      range_status;

  modport source (output valid, output temperature_centi, output range_status, input ready);
  modport sink   (input valid, input temperature_centi, input range_status, output ready);
endinterface

// File: rtl/ntcdtl_div.sv
module ntcdtl_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ntcdtl_pkg::DIV_DEN_W-1:0] rem_init,
  input  logic [ntcdtl_pkg::DIV_NUM_W-1:0] quo_init,
  input  logic [ntcdtl_pkg::DIV_DEN_W-1:0] den,
  input  logic [ntcdtl_pkg::DIV_CNT_W-1:0] count,
  output logic                             busy,
  output logic [ntcdtl_pkg::DIV_NUM_W-1:0] quo,
  output logic [ntcdtl_pkg::DIV_DEN_W-1:0] rem
);

  localparam int NW = ntcdtl_pkg::DIV_NUM_W;
  localparam int DW = ntcdtl_pkg::DIV_DEN_W;
  localparam int CW = ntcdtl_pkg::DIV_CNT_W;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = rem_init;
      quo_nxt  = quo_init;
      cnt_nxt  = count;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// File: rtl/ntcdtl_dp.sv
module ntcdtl_dp #(
  parameter int TABLE_ENTRIES = ntcdtl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ntcdtl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ntcdtl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [ntcdtl_pkg::ADC_W-1:0]          in_adc,
  input  ntcdtl_pkg::cmd_t                      cmd,
  output ntcdtl_pkg::sts_t                      sts,
  output logic signed [ntcdtl_pkg::TEMP_W-1:0]  out_temp,
  output logic [ntcdtl_pkg::STATUS_W-1:0]       out_status
);

  localparam int USED = ntcdtl_pkg::used_entries(TABLE_ENTRIES);
  localparam int IW   = $clog2(USED);
  localparam int OW   = ntcdtl_pkg::OHM_W;
  localparam int SW   = ntcdtl_pkg::STORED_IDX_W;
  localparam int TW   = ntcdtl_pkg::TEMP_W;

  localparam logic [OW-1:0] RMAX = ntcdtl_pkg::ohms_q4(SW'(0));
  localparam logic [OW-1:0] RMIN = ntcdtl_pkg::ohms_q4(SW'(USED - 1));
  localparam logic [TW-1:0] COLD_T = TW'(ntcdtl_pkg::LOWEST_CENTI);
  localparam logic [TW-1:0] HOT_T  =
    TW'(ntcdtl_pkg::LOWEST_CENTI + ntcdtl_pkg::STEP_CENTI * (USED - 1));

  // configuration
  logic [ntcdtl_pkg::SUP_W-1:0]  sup_r;
  logic [ntcdtl_pkg::DIVR_W-1:0] divr_r;
  logic                          upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r   <= ntcdtl_pkg::SUPPLY_RST;
      divr_r  <= ntcdtl_pkg::DIVIDER_RST;
      upper_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntcdtl_pkg::CFG_SUPPLY:    sup_r   <= cfg_wdata[ntcdtl_pkg::SUP_W-1:0];
        ntcdtl_pkg::CFG_DIVIDER:   divr_r  <= cfg_wdata[ntcdtl_pkg::DIVR_W-1:0];
        ntcdtl_pkg::CFG_NTC_UPPER: upper_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [ntcdtl_pkg::ADC_W-1:0] v_r;
  logic [OW-1:0]                r16;

  assign r16 = {divr_r, 4'b0000};

  // span check products
  logic [OW-1:0] v_addend;
  logic [OW-1:0] s_op;
  logic [OW:0]   v_sum;
  logic [40:0]   pv, pv_r;
  logic [36:0]   ps, ps_r;

  assign v_addend = (upper_r == cmd.span_sel) ? RMAX : RMIN;
  assign s_op     = upper_r ? r16 : (cmd.span_sel ? RMIN : RMAX);
  assign v_sum    = {1'b0, r16} + {1'b0, v_addend};
  assign pv       = 41'(v_r) * 41'(v_sum);
  assign ps       = 37'(sup_r) * 37'(s_op);

  // resistance division setup
  logic [ntcdtl_pkg::ADC_W-1:0]     dsv;
  logic [ntcdtl_pkg::ADC_W-1:0]     mul_b;
  logic [ntcdtl_pkg::DIV_NUM_W-1:0] num1;
  logic [ntcdtl_pkg::DIV_DEN_W-1:0] den1;
  logic                             sat_now, sat_r;

  assign dsv   = {3'b000, sup_r} - v_r;
  assign mul_b = upper_r ? dsv : v_r;
  assign num1  = 40'(r16) * 40'(mul_b);
  assign den1  = upper_r ? {8'h00, v_r} : {8'h00, dsv};
  assign sat_now = upper_r ? (({3'b000, sup_r} < v_r) || (v_r == '0))
                           : ({3'b000, sup_r} <= v_r);

  // table search
  logic [ntcdtl_pkg::RES_W-1:0] res_r;
  logic [IW-1:0]                lo_r, hi_r;
  logic [IW:0]                  mid_sum;
  logic [IW-1:0]                mid;
  logic [IW:0]                  mid_p1;
  logic [IW:0]                  lo_p1;
  logic [OW-1:0]                t_mid;
  logic [OW-1:0]                t_hi, t_lo;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IW:1];
  assign mid_p1  = {1'b0, mid} + (IW+1)'(1);
  assign lo_p1   = {1'b0, lo_r} + (IW+1)'(1);
  assign t_mid   = ntcdtl_pkg::ohms_q4(SW'(mid_p1));
  assign t_hi    = ntcdtl_pkg::ohms_q4(SW'(lo_r));
  assign t_lo    = ntcdtl_pkg::ohms_q4(SW'(lo_p1));

  // interpolation division setup
  logic [OW-1:0] den2;
  logic [OW-1:0] dr;
  logic [32:0]   n2;

  assign den2 = t_hi - t_lo;
  assign dr   = t_hi - res_r[OW-1:0];
  assign n2   = 33'(dr) * 33'(ntcdtl_pkg::STEP_CENTI);

  // shared divider
  logic                             div_start;
  logic [ntcdtl_pkg::DIV_DEN_W-1:0] div_rem_init;
  logic [ntcdtl_pkg::DIV_NUM_W-1:0] div_quo_init;
  logic [ntcdtl_pkg::DIV_DEN_W-1:0] div_den;
  logic [ntcdtl_pkg::DIV_CNT_W-1:0] div_count;
  logic                             div_busy;
  logic [ntcdtl_pkg::DIV_NUM_W-1:0] div_quo;
  logic [ntcdtl_pkg::DIV_DEN_W-1:0] div_rem;

  assign div_start    = cmd.div1_start | cmd.div2_start;
  assign div_rem_init = cmd.div2_start ? 24'(n2[32:10]) : '0;
  assign div_quo_init = cmd.div2_start ? {n2[9:0], 30'b0} : num1;
  assign div_den      = cmd.div2_start ? den2 : den1;
  assign div_count    = cmd.div2_start ? ntcdtl_pkg::DIV_CNT_W'(ntcdtl_pkg::DIV_SHORT)
                                       : ntcdtl_pkg::DIV_CNT_W'(ntcdtl_pkg::DIV_FULL);

  ntcdtl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .den      (div_den),
    .count    (div_count),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // interpolated temperature, truncated toward zero
  logic [16:0] base;
  logic [16:0] interp_sum;
  logic [16:0] interp;

  assign base = 17'(ntcdtl_pkg::LOWEST_CENTI)
              + 17'(17'(lo_r) * 17'(ntcdtl_pkg::STEP_CENTI));
  assign interp_sum = base + 17'(div_quo[9:0]);
  assign interp = (interp_sum[16] && (div_rem != '0)) ? interp_sum + 17'd1 : interp_sum;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      v_r <= in_adc;
    end
    if (cmd.mul) begin
      pv_r <= pv;
      ps_r <= ps;
    end
    if (cmd.div1_start) begin
      sat_r <= sat_now;
    end
    if (cmd.res_load) begin
      res_r <= (sat_r || (div_quo[39:32] != '0)) ? '1 : div_quo[31:0];
      lo_r  <= '0;
      hi_r  <= IW'(USED - 2);
    end else if (cmd.srch_step) begin
      if ({8'h00, t_mid} <= res_r) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid_p1[IW-1:0];
      end
    end
    if (cmd.out_load) begin
      unique case (cmd.res_sel)
        ntcdtl_pkg::SEL_COLD_FLAG: begin
          out_temp   <= COLD_T;
          out_status <= ntcdtl_pkg::ST_ABOVE;
        end
        ntcdtl_pkg::SEL_HOT_FLAG: begin
          out_temp   <= HOT_T;
          out_status <= ntcdtl_pkg::ST_BELOW;
        end
        ntcdtl_pkg::SEL_COLD: begin
          out_temp   <= COLD_T;
          out_status <= ntcdtl_pkg::ST_VALID;
        end
        ntcdtl_pkg::SEL_HOT: begin
          out_temp   <= HOT_T;
          out_status <= ntcdtl_pkg::ST_VALID;
        end
        default: begin
          out_temp   <= interp[TW-1:0];
          out_status <= ntcdtl_pkg::ST_VALID;
        end
      endcase
    end
  end

  assign sts.gt         = pv_r > {4'h0, ps_r};
  assign sts.lt         = pv_r < {4'h0, ps_r};
  assign sts.div_busy   = div_busy;
  assign sts.clamp_cold = res_r >= {8'h00, RMAX};
  assign sts.clamp_hot  = res_r <= {8'h00, RMIN};
  assign sts.srch_done  = lo_r == hi_r;

endmodule

// File: rtl/ntcdtl_ctrl.sv
module ntcdtl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ntcdtl_pkg::sts_t sts,
  output ntcdtl_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SPAN_A = 8'b0000_0010,
    S_SPAN_B = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_DIV1   = 8'b0001_0000,
    S_SRCH   = 8'b0010_0000,
    S_DIV2   = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  ntcdtl_pkg::res_sel_t  sel_r, sel_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_comb begin
    cmd         = '0;
    cmd.res_sel = sel_r;
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_SPAN_A;
        end
      end
      S_SPAN_A: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SPAN_B;
      end
      S_SPAN_B: begin
        if (sts.gt) begin
          sel_nxt   = ntcdtl_pkg::SEL_COLD_FLAG;
          state_nxt = S_FIN;
        end else begin
          cmd.mul      = 1'b1;
          cmd.span_sel = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.lt) begin
          sel_nxt   = ntcdtl_pkg::SEL_HOT_FLAG;
          state_nxt = S_FIN;
        end else begin
          cmd.div1_start = 1'b1;
          state_nxt      = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!sts.div_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_SRCH;
        end
      end
      S_SRCH: begin
        priority if (sts.clamp_cold) begin
          sel_nxt   = ntcdtl_pkg::SEL_COLD;
          state_nxt = S_FIN;
        end else if (sts.clamp_hot) begin
          sel_nxt   = ntcdtl_pkg::SEL_HOT;
          state_nxt = S_FIN;
        end else if (sts.srch_done) begin
          cmd.div2_start = 1'b1;
          state_nxt      = S_DIV2;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_DIV2: begin
        if (!sts.div_busy) begin
          sel_nxt   = ntcdtl_pkg::SEL_INTERP;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= ntcdtl_pkg::SEL_COLD_FLAG;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/ntc_divider_temperature_lookup.sv
// from accept to result: the span check, then the resistance divide (40 bit-serial steps),
// the binary search, the interpolation divide and the result load, all on one shared
// divider; a word above or below the span goes to the result load after the span check,
// and one whose resistance lands on or past a table end skips the search and second divide
// throughput: one word at a time; the next word is taken the cycle after the result
// is loaded, even while it waits; reset: synchronous, active low, 3000 mV, 10000 ohm, lower
module ntc_divider_temperature_lookup #(
  parameter int TABLE_ENTRIES = ntcdtl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ntcdtl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntcdtl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ntcdtl_in_if.sink                         in_if,
  ntcdtl_out_if.source                      out_if
);

  localparam int USED = ntcdtl_pkg::used_entries(TABLE_ENTRIES);
  localparam int TW   = ntcdtl_pkg::TEMP_W;
  localparam logic signed [TW-1:0] COLD_T = TW'(ntcdtl_pkg::LOWEST_CENTI);
  localparam logic signed [TW-1:0] HOT_T  =
    TW'(ntcdtl_pkg::LOWEST_CENTI + ntcdtl_pkg::STEP_CENTI * (USED - 1));

  ntcdtl_pkg::cmd_t cmd_w;
  ntcdtl_pkg::sts_t sts_w;

  ntcdtl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts_w),
    .cmd       (cmd_w)
  );

  ntcdtl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_adc     (in_if.adc_millivolts),
    .cmd        (cmd_w),
    .sts        (sts_w),
    .out_temp   (out_if.temperature_centi),
    .out_status (out_if.range_status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input taken while a word is in flight");

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_w.div1_start |=> sts_w.div_busy)
    else $error("divider did not start");

  a_above_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.range_status == ntcdtl_pkg::ST_ABOVE)
      |-> out_if.temperature_centi == COLD_T)
    else $error("above span without coldest temperature");

  a_below_hot: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.range_status == ntcdtl_pkg::ST_BELOW)
      |-> out_if.temperature_centi == HOT_T)
    else $error("below span without hottest temperature");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.temperature_centi >= COLD_T)
                     && (out_if.temperature_centi <= HOT_T))
    else $error("temperature outside table range");

endmodule
